// ===== src/sss_pkg.sv =====
package sss_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [31:0] EMPTY_MARK = 32'hffff_ffff;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_TEST   = 2'd2,
    KIND_ERASE  = 2'd3
  } sss_kind_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
  } sss_in_t;

  typedef struct packed {
    logic        was_present;
    logic        dropped;
    logic [6:0]  member_count;
    logic [31:0] first_member;
    logic        is_empty;
  } sss_out_t;

endpackage

// ===== src/small_set_store_core.sv =====
// Set of 32-bit labels kept as a packed list in insertion order in an entry
// memory with one read and one write port, read one entry a cycle. Every
// transaction passes through an accepting state and, after any scan or
// compaction, a done state that hands the result to the output register
// once it is free or taken; an erase goes from accepting straight to done.
// Add, test and remove scan the list from the oldest entry and stop at the
// first match or after the newest entry. A remove of a present label then
// compacts the list, one entry moved down per cycle, each later entry moving
// down one place. The input stalls while a transaction is in progress, and a
// new transaction may start while the previous result still waits to be
// taken. An add of a new label to a full set leaves the set unchanged and
// flags it.
module small_set_store_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sss_pkg::sss_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sss_pkg::sss_out_t out_data_o
);
  import sss_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [31:0] mem [CAPACITY];
  logic [31:0] rd_data_q;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       wr_data;

  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  logic [ADDR_W-1:0] pidx_q, pidx_d;
  logic [31:0]       first_q, first_d;
  logic [31:0]       val_q, val_d;
  logic [1:0]        kind_q, kind_d;
  logic              hit_q, hit_d;
  logic              drop_q, drop_d;
  sss_out_t          out_q, out_d;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pend_d      = 1'b0;
    pidx_d      = idx_q[ADDR_W-1:0];
    first_d     = first_q;
    val_d       = val_q;
    kind_d      = kind_q;
    hit_d       = hit_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    rd_en       = 1'b0;
    rd_addr     = idx_q[ADDR_W-1:0];
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = rd_data_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d = in_data_i.kind;
          val_d  = in_data_i.value;
          hit_d  = 1'b0;
          drop_d = 1'b0;
          idx_d  = '0;
          if (in_data_i.kind == KIND_ERASE) begin
            count_d = '0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (pend_q && (rd_data_q == val_q)) begin
          hit_d = 1'b1;
          if (kind_q == KIND_REMOVE) begin
            idx_d   = CNT_W'(pidx_q) + CNT_W'(1);
            state_d = ST_SHIFT;
          end else begin
            state_d = ST_DONE;
          end
        end else if (idx_q < count_q) begin
          rd_en  = 1'b1;
          pend_d = 1'b1;
          idx_d  = idx_q + CNT_W'(1);
        end else if (!pend_q) begin
          // miss: append on add unless full
          if (kind_q == KIND_ADD) begin
            if (count_q >= CNT_W'(CAPACITY)) begin
              drop_d = 1'b1;
            end else begin
              wr_en   = 1'b1;
              wr_addr = count_q[ADDR_W-1:0];
              wr_data = val_q;
              count_d = count_q + CNT_W'(1);
              if (count_q == '0) begin
                first_d = val_q;
              end
            end
          end
          state_d = ST_DONE;
        end
      end
      ST_SHIFT: begin
        // move the entry read last cycle down one place
        if (pend_q) begin
          wr_en   = 1'b1;
          wr_addr = pidx_q - ADDR_W'(1);
          wr_data = rd_data_q;
          if (pidx_q == ADDR_W'(1)) begin
            first_d = rd_data_q;
          end
        end
        if (idx_q < count_q) begin
          rd_en  = 1'b1;
          pend_d = 1'b1;
          idx_d  = idx_q + CNT_W'(1);
        end else if (!pend_q) begin
          count_d = count_q - CNT_W'(1);
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d        = 1'b1;
          out_d.was_present  = hit_q;
          out_d.dropped      = drop_q;
          out_d.member_count = 7'(count_q);
          out_d.first_member = (count_q == '0) ? EMPTY_MARK : first_q;
          out_d.is_empty     = (count_q == '0);
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q  <= pidx_d;
    first_q <= first_d;
    val_q   <= val_d;
    kind_q  <= kind_d;
    hit_q   <= hit_d;
    drop_q  <= drop_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  import sss_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned HOLDOFF_AT     = 80;
  localparam int unsigned QUIET_TAIL     = 60;
  localparam int unsigned DRAIN_A        = 150;
  localparam int unsigned DRAIN_B        = 350;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  sss_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  sss_out_t out_data_o;

  small_set_store_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  sss_in_t     pending_q[$];
  sss_out_t    expected_q[$];
  logic [31:0] label_set_q[$];

  int unsigned total_items    = 0;
  int unsigned items_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatches     = 0;
  int unsigned idle_cycles    = 0;
  int unsigned send_gap       = 0;
  int unsigned recv_gap       = 0;
  int unsigned holdoff_left   = 0;
  bit          holdoff_done   = 1'b0;

  // Apply one operation to the shadow set and return the result it yields.
  function automatic sss_out_t apply_set_op(sss_in_t op);
    sss_out_t r;
    int       pos;
    r   = '0;
    pos = -1;
    foreach (label_set_q[i]) begin
      if (pos < 0 && label_set_q[i] == op.value) pos = i;
    end
    case (sss_kind_e'(op.kind))
      KIND_ADD: begin
        r.was_present = (pos >= 0);
        if (pos < 0) begin
          if (label_set_q.size() >= CAPACITY) r.dropped = 1'b1;
          else label_set_q.push_back(op.value);
        end
      end
      KIND_REMOVE: begin
        r.was_present = (pos >= 0);
        if (pos >= 0) label_set_q.delete(pos);
      end
      KIND_TEST: begin
        r.was_present = (pos >= 0);
      end
      default: begin
        label_set_q.delete();
      end
    endcase
    r.member_count = 7'(label_set_q.size());
    r.is_empty     = (label_set_q.size() == 0);
    r.first_member = r.is_empty ? EMPTY_MARK : label_set_q[0];
    return r;
  endfunction

  task automatic queue_op(sss_kind_e k, logic [31:0] v);
    sss_in_t op;
    op.kind  = k;
    op.value = v;
    pending_q.push_back(op);
  endtask

  // Erase, fill to capacity with distinct labels, then poke at the full set.
  task automatic queue_fill_phase();
    logic [31:0] base;
    logic [31:0] stride;
    int unsigned n;
    base   = $urandom;
    stride = $urandom | 32'h1;
    n      = CAPACITY + $urandom_range(0, 4);
    queue_op(KIND_ERASE, $urandom);
    for (int unsigned i = 0; i < n; i++) queue_op(KIND_ADD, base + i * stride);
    repeat ($urandom_range(1, 4)) queue_op(KIND_ADD, $urandom);
    queue_op(KIND_ADD, base);
    queue_op(KIND_TEST, base + $urandom_range(0, CAPACITY - 1) * stride);
    queue_op(KIND_REMOVE, base + $urandom_range(1, CAPACITY - 2) * stride);
    queue_op(KIND_REMOVE, base);
    queue_op(KIND_TEST, base);
    queue_op(KIND_ADD, base + (CAPACITY - 1) * stride);
    queue_op(KIND_ADD, $urandom);
    queue_op(KIND_ADD, $urandom);
    queue_op(KIND_REMOVE, base + (CAPACITY - 1) * stride);
  endtask

  // Operations over a small label pool so hits and misses are both common.
  task automatic queue_pool_phase();
    logic [31:0] pool[8];
    int unsigned pick;
    foreach (pool[i]) pool[i] = $urandom;
    if ($urandom_range(0, 1)) pool[0] = 32'h0;
    if ($urandom_range(0, 1)) pool[1] = EMPTY_MARK;
    repeat (30) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      queue_op(KIND_ADD, pool[$urandom_range(0, 7)]);
      else if (pick < 65) queue_op(KIND_REMOVE, pool[$urandom_range(0, 7)]);
      else if (pick < 95) queue_op(KIND_TEST, pool[$urandom_range(0, 7)]);
      else                queue_op(KIND_ERASE, $urandom);
    end
  endtask

  task automatic report_mismatch(sss_out_t exp, sss_out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at result %0d: expected present=%0b dropped=%0b count=%0d",
               results_seen, exp.was_present, exp.dropped, exp.member_count);
      $display("    expected first=%h empty=%0b", exp.first_member, exp.is_empty);
      $display("    got present=%0b dropped=%0b count=%0d first=%h empty=%0b",
               got.was_present, got.dropped, got.member_count,
               got.first_member, got.is_empty);
    end
  endtask

  task automatic check_result(sss_out_t got);
    sss_out_t exp;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %0d: first=%h", results_seen,
                                     got.first_member);
    end else begin
      exp = expected_q.pop_front();
      if (got.was_present !== exp.was_present || got.dropped !== exp.dropped ||
          got.member_count !== exp.member_count || got.first_member !== exp.first_member ||
          got.is_empty !== exp.is_empty) report_mismatch(exp, got);
    end
  endtask

  // Sender: hold a stalled transaction, otherwise pick gap, drain pause or next item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_q.push_back(apply_set_op(in_data_i));
        void'(pending_q.pop_front());
        items_accepted++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if ((items_accepted == DRAIN_A || items_accepted == DRAIN_B) &&
                     expected_q.size() != 0) begin
          in_valid_i <= 1'b0;
        end else if (items_accepted + QUIET_TAIL < total_items &&
                     (items_accepted / 64) % 3 != 2 && $urandom_range(0, 7) == 0) begin
          send_gap   = $urandom_range(1, 9) - 1;
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_q[0];
        end
      end
    end
  end

  // Receiver: check each transaction, then decide the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        check_result(out_data_o);
        results_seen++;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall_i <= 1'b1;
      end else if (!holdoff_done && results_seen == HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_CYCLES - 1;
        out_stall_i  <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall_i <= 1'b1;
      end else if (results_seen + QUIET_TAIL < total_items &&
                   (results_seen / 64) % 3 != 1 && $urandom_range(0, 5) == 0) begin
        recv_gap    = $urandom_range(1, 9) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) idle_cycles <= 0;
    else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned phase;
    // Directed: empty set, present and absent labels, compaction, erase.
    queue_op(KIND_ERASE, 32'h0);
    queue_op(KIND_TEST, 32'h0);
    queue_op(KIND_REMOVE, 32'h0);
    queue_op(KIND_ADD, 32'h0);
    queue_op(KIND_ADD, EMPTY_MARK);
    queue_op(KIND_ADD, 32'h0);
    queue_op(KIND_TEST, EMPTY_MARK);
    queue_op(KIND_TEST, 32'h1);
    queue_op(KIND_ADD, 32'ha5a5_a5a5);
    queue_op(KIND_REMOVE, EMPTY_MARK);
    queue_op(KIND_REMOVE, 32'h0);
    queue_op(KIND_REMOVE, 32'h5a5a_5a5a);
    queue_op(KIND_ADD, 32'h5a5a_5a5a);
    queue_op(KIND_ERASE, EMPTY_MARK);
    queue_op(KIND_TEST, 32'ha5a5_a5a5);
    queue_op(KIND_ADD, 32'h1);
    queue_op(KIND_ADD, 32'h8000_0000);
    queue_op(KIND_REMOVE, 32'h1);
    queue_op(KIND_TEST, 32'h8000_0000);
    queue_op(KIND_ERASE, 32'h0);

    phase = 0;
    while (pending_q.size() < 500) begin
      if (phase == 0 || phase == 7 || $urandom_range(0, 9) == 0) begin
        queue_fill_phase();
      end else if ($urandom_range(0, 4) == 0) begin
        repeat (10) queue_op(sss_kind_e'($urandom_range(0, 3)), $urandom);
      end else begin
        queue_pool_phase();
      end
      phase++;
    end
    total_items = pending_q.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(items_accepted == total_items && expected_q.size() == 0)) @(posedge clk_i);
    repeat (2 * CAPACITY + 20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
